@@ rtl/npcm_pkg.sv @@
// -----------------------------------------------------------------------------
// npcm_pkg
// Shared widths, codes and control structs for the nearest palette mapper.
// -----------------------------------------------------------------------------
package npcm_pkg;

    // Default sizing, handed to the top level parameters
    localparam int PALETTE_ENTRIES_DEF = 256;
    localparam int MAX_LINE_WIDTH_DEF  = 4096;

    // Fixed field widths
    localparam int OP_W       = 2;
    localparam int WORD_W     = 32;
    localparam int IDX_W      = 8;
    localparam int PEN_W      = 8;
    localparam int CH_W       = 8;
    localparam int MASK_W     = 8;
    localparam int FMT_W      = 2;
    localparam int LW_W       = 13;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 13;
    localparam int SQ_W       = 2 * CH_W;
    localparam int ERR_W      = SQ_W + 2;

    // Item operations
    localparam logic [OP_W-1:0] OP_PIXEL  = 2'd0;
    localparam logic [OP_W-1:0] OP_PAL_WR = 2'd1;
    localparam logic [OP_W-1:0] OP_PEN_WR = 2'd2;

    // Pixel formats
    localparam logic [FMT_W-1:0] FMT_CLUT8  = 2'd0;
    localparam logic [FMT_W-1:0] FMT_RGB24  = 2'd1;
    localparam logic [FMT_W-1:0] FMT_ARGB32 = 2'd2;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_FORMAT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LINE_WIDTH   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MASK_ENABLE  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_PEN_REMAP    = 2'd3;

    localparam logic [CH_W-1:0]   OPAQUE_MIN = 8'h80;
    localparam logic [MASK_W-1:0] MASK_MSB   = 8'h80;
    localparam logic [7:0]        ALPHA_FULL = 8'hFF;

    // Controller -> datapath
    typedef struct packed {
        logic load_pixel;
        logic wr_pal;
        logic wr_pen;
        logic fetch;
        logic decode;
        logic issue;
        logic load_out;
    } t_cmd;

    // Datapath -> controller
    typedef struct packed {
        logic is_clut;
        logic last_issue;
        logic pipe_empty;
        logic exact_hit;
    } t_status;

endpackage

@@ rtl/npcm_if.sv @@
// -----------------------------------------------------------------------------
// npcm_if
// Handshake channels: input items, result items and register writes.
// -----------------------------------------------------------------------------
interface npcm_pix_if;
    import npcm_pkg::*;

    logic                valid;
    logic                ready;
    logic [OP_W-1:0]     operation;
    logic [WORD_W-1:0]   pixel_word;
    logic [IDX_W-1:0]    entry_index;
    logic [WORD_W-1:0]   entry_word;

    modport source (output valid, operation, pixel_word, entry_index, entry_word,
                    input ready);
    modport sink   (input valid, operation, pixel_word, entry_index, entry_word,
                    output ready);
endinterface

interface npcm_res_if;
    import npcm_pkg::*;

    logic              valid;
    logic              ready;
    logic [PEN_W-1:0]  pen;
    logic              opaque;
    logic [MASK_W-1:0] mask_byte;
    logic              mask_byte_ready;

    modport source (output valid, pen, opaque, mask_byte, mask_byte_ready,
                    input ready);
    modport sink   (input valid, pen, opaque, mask_byte, mask_byte_ready,
                    output ready);
endinterface

interface npcm_cfg_if;
    import npcm_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

@@ rtl/npcm_ram.sv @@
// -----------------------------------------------------------------------------
// npcm_ram
// Generic single-write, single-read RAM with registered read data.
// -----------------------------------------------------------------------------
module npcm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

@@ rtl/npcm_ctrl.sv @@
// -----------------------------------------------------------------------------
// npcm_ctrl
// Sequencer: item intake, palette scan, pen lookup and result hand-off.
// -----------------------------------------------------------------------------
module npcm_ctrl (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    input  logic [npcm_pkg::OP_W-1:0]  i_in_op,
    output logic                       o_in_ready,
    output logic                       o_out_valid,
    input  logic                       i_out_ready,
    input  npcm_pkg::t_status          i_status,
    output npcm_pkg::t_cmd             o_cmd
);
    import npcm_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_FETCH,
        S_DECODE,
        S_SCAN,
        S_DRAIN,
        S_PEN,
        S_EMIT
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;

    always_comb begin
        o_cmd       = '0;
        n_state     = r_state;
        n_out_valid = r_out_valid && !i_out_ready;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    case (i_in_op)
                        OP_PIXEL: begin
                            o_cmd.load_pixel = 1'b1;
                            n_state = i_status.is_clut ? S_FETCH : S_SCAN;
                        end
                        OP_PAL_WR: o_cmd.wr_pal = 1'b1;
                        OP_PEN_WR: o_cmd.wr_pen = 1'b1;
                        default: ;
                    endcase
                end
            end
            S_FETCH: begin
                o_cmd.fetch = 1'b1;
                n_state     = S_DECODE;
            end
            S_DECODE: begin
                o_cmd.decode = 1'b1;
                n_state      = S_SCAN;
            end
            S_SCAN: begin
                if (i_status.exact_hit) begin
                    n_state = S_PEN;
                end else begin
                    o_cmd.issue = 1'b1;
                    if (i_status.last_issue) begin
                        n_state = S_DRAIN;
                    end
                end
            end
            S_DRAIN: begin
                if (i_status.exact_hit || i_status.pipe_empty) begin
                    n_state = S_PEN;
                end
            end
            S_PEN: n_state = S_EMIT;
            S_EMIT: begin
                // wait for the result register to free up
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.load_out = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
endmodule

@@ rtl/npcm_dp.sv @@
// -----------------------------------------------------------------------------
// npcm_dp
// Datapath: registers, palette and pen memories, distance pipe, mask packer.
// -----------------------------------------------------------------------------
module npcm_dp #(
    parameter int PALETTE_ENTRIES = npcm_pkg::PALETTE_ENTRIES_DEF,
    parameter int MAX_LINE_WIDTH  = npcm_pkg::MAX_LINE_WIDTH_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  npcm_pkg::t_cmd                   i_cmd,
    output npcm_pkg::t_status                o_status,
    input  logic [npcm_pkg::WORD_W-1:0]      i_pixel_word,
    input  logic [npcm_pkg::IDX_W-1:0]       i_entry_index,
    input  logic [npcm_pkg::WORD_W-1:0]      i_entry_word,
    input  logic                             i_cfg_valid,
    input  logic [npcm_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [npcm_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    output logic [npcm_pkg::PEN_W-1:0]       o_pen,
    output logic                             o_opaque,
    output logic [npcm_pkg::MASK_W-1:0]      o_mask_byte,
    output logic                             o_mask_byte_ready
);
    import npcm_pkg::*;

    localparam int PW = $clog2(PALETTE_ENTRIES);
    localparam int CW = $clog2(MAX_LINE_WIDTH);
    localparam int EW = (CW + 1 > LW_W) ? CW + 1 : LW_W;

    // Configuration
    logic [FMT_W-1:0] r_fmt;
    logic [LW_W-1:0]  r_line_width;
    logic             r_mask_en;
    logic             r_remap_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fmt        <= FMT_CLUT8;
            r_line_width <= LW_W'(1);
            r_mask_en    <= 1'b0;
            r_remap_en   <= 1'b0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_IMAGE_FORMAT: r_fmt        <= i_cfg_data[FMT_W-1:0];
                REG_LINE_WIDTH:   r_line_width <= i_cfg_data[LW_W-1:0];
                REG_MASK_ENABLE:  r_mask_en    <= i_cfg_data[0];
                REG_PEN_REMAP:    r_remap_en   <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // Memories
    logic [PW-1:0]     pal_raddr;
    logic [WORD_W-1:0] pal_rdata;
    logic              pal_we;
    logic [PEN_W-1:0]  pen_rdata;
    logic [PW-1:0]     r_addr;
    logic [IDX_W-1:0]  r_clut_idx;
    logic [PW-1:0]     r_best;

    assign pal_we    = i_cmd.wr_pal &&
                       ({1'b0, i_entry_index} < (IDX_W + 1)'(PALETTE_ENTRIES));
    assign pal_raddr = i_cmd.fetch ? r_clut_idx[PW-1:0] : r_addr;

    npcm_ram #(.WIDTH(WORD_W), .DEPTH(PALETTE_ENTRIES)) u_pal_ram (
        .i_clk   (i_clk),
        .i_we    (pal_we),
        .i_waddr (i_entry_index[PW-1:0]),
        .i_wdata (i_entry_word),
        .i_raddr (pal_raddr),
        .o_rdata (pal_rdata)
    );

    npcm_ram #(.WIDTH(PEN_W), .DEPTH(1 << IDX_W)) u_pen_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.wr_pen),
        .i_waddr (i_entry_index),
        .i_wdata (i_entry_word[PEN_W-1:0]),
        .i_raddr (IDX_W'(r_best)),
        .o_rdata (pen_rdata)
    );

    // Decoded pixel color
    logic [CH_W-1:0]   r_a, r_r, r_g, r_b;
    logic [WORD_W-1:0] dec_word;
    logic              clut_in_range;

    always_comb begin
        case (r_fmt)
            FMT_RGB24:  dec_word = {ALPHA_FULL, i_pixel_word[23:0]};
            FMT_ARGB32: dec_word = i_pixel_word;
            default:    dec_word = '0;
        endcase
    end

    assign clut_in_range = ({1'b0, r_clut_idx} < (IDX_W + 1)'(PALETTE_ENTRIES));

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_pixel) begin
            {r_a, r_r, r_g, r_b} <= dec_word;
            r_clut_idx           <= i_pixel_word[IDX_W-1:0];
        end else if (i_cmd.decode) begin
            {r_a, r_r, r_g, r_b} <= clut_in_range ? pal_rdata : '0;
        end
    end

    // Distance pipe: read -> squares -> sum and compare
    logic             r_v1, r_v2;
    logic [PW-1:0]    r_i1, r_i2;
    logic [SQ_W-1:0]  r_sq_r, r_sq_g, r_sq_b;
    logic [ERR_W-1:0] r_best_err;
    logic [CH_W-1:0]  d_r, d_g, d_b;
    logic [ERR_W-1:0] err;

    assign d_r = (pal_rdata[23:16] > r_r) ? pal_rdata[23:16] - r_r : r_r - pal_rdata[23:16];
    assign d_g = (pal_rdata[15:8] > r_g) ? pal_rdata[15:8] - r_g : r_g - pal_rdata[15:8];
    assign d_b = (pal_rdata[7:0] > r_b) ? pal_rdata[7:0] - r_b : r_b - pal_rdata[7:0];
    assign err = ERR_W'(r_sq_r) + ERR_W'(r_sq_g) + ERR_W'(r_sq_b);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            r_v1 <= i_cmd.issue;
            r_v2 <= r_v1 && !i_cmd.load_pixel;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_pixel) begin
            r_addr <= '0;
        end else if (i_cmd.issue) begin
            r_addr <= r_addr + PW'(1);
        end
        r_i1   <= r_addr;
        r_i2   <= r_i1;
        r_sq_r <= SQ_W'(d_r) * SQ_W'(d_r);
        r_sq_g <= SQ_W'(d_g) * SQ_W'(d_g);
        r_sq_b <= SQ_W'(d_b) * SQ_W'(d_b);
        // strict compare keeps the lowest index on ties
        if (i_cmd.load_pixel) begin
            r_best_err <= '1;
            r_best     <= '0;
        end else if (r_v2 && (err < r_best_err)) begin
            r_best_err <= err;
            r_best     <= r_i2;
        end
    end

    assign o_status.is_clut    = (r_fmt == FMT_CLUT8);
    assign o_status.last_issue = (r_addr == PW'(PALETTE_ENTRIES - 1));
    assign o_status.pipe_empty = !r_v1 && !r_v2;
    assign o_status.exact_hit  = (r_best_err == '0);

    // Mask packing
    logic [CW-1:0]     r_col;
    logic [MASK_W-1:0] r_acc;
    logic [EW-1:0]     lw_ext, eff_width;
    logic              active, opaque, row_end, group_end;
    logic [2:0]        bitpos;
    logic [MASK_W-1:0] acc_or;

    always_comb begin
        lw_ext = EW'(r_line_width);
        if (lw_ext == '0) begin
            eff_width = EW'(1);
        end else if (lw_ext > EW'(MAX_LINE_WIDTH)) begin
            eff_width = EW'(MAX_LINE_WIDTH);
        end else begin
            eff_width = lw_ext;
        end
        active    = (r_fmt == FMT_ARGB32) && r_mask_en;
        opaque    = active && (r_a >= OPAQUE_MIN);
        bitpos    = r_col[2:0];
        acc_or    = opaque ? (r_acc | (MASK_MSB >> bitpos)) : r_acc;
        row_end   = ((EW'(r_col) + EW'(1)) >= eff_width);
        group_end = (bitpos == 3'd7) || row_end;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_acc <= '0;
        end else if (i_cmd.load_out) begin
            r_col <= row_end ? '0 : r_col + CW'(1);
            r_acc <= group_end ? '0 : acc_or;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            o_pen             <= r_remap_en ? pen_rdata : PEN_W'(r_best);
            o_opaque          <= opaque;
            o_mask_byte       <= (group_end && active) ? acc_or : '0;
            o_mask_byte_ready <= group_end && active;
        end
    end
endmodule

@@ rtl/nearest_palette_color_mapper_unit.sv @@
// -----------------------------------------------------------------------------
// nearest_palette_color_mapper_unit
// Maps pixels to the nearest palette entry, with optional pen remap and mask.
// -----------------------------------------------------------------------------
// Usage:
//   i_pix carries items: pixels (CLUT8, RGB24 or ARGB32 per image_format),
//   palette writes and pen table writes. Load every palette entry before
//   the first pixel. i_cfg writes the four registers; the user must do so
//   only while the block idles, which the block does not enforce. o_res
//   returns one item per pixel: pen, opaque bit and, at group or row ends
//   with ARGB32 masking on, a packed mask byte. Table writes return nothing.
// Timing:
//   A pixel's result is loaded after the palette scan, the pipe drain and
//   the pen lookup (CLUT8 first reads its color from the palette), or
//   sooner when an exact match ends the scan. The next item can be taken in
//   the cycle after the result is loaded. The scan reads one palette entry
//   per cycle through the palette memory's single read port.
// Reset clears the registers to their defaults, the column counter and the
//   mask accumulator; the palette and pen tables hold garbage until written.
// A stalled receiver holds the result in the output register; the block
//   still takes the next item and only waits before handing over its result.
// -----------------------------------------------------------------------------
module nearest_palette_color_mapper_unit #(
    parameter int PALETTE_ENTRIES = npcm_pkg::PALETTE_ENTRIES_DEF,
    parameter int MAX_LINE_WIDTH  = npcm_pkg::MAX_LINE_WIDTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    npcm_pix_if.sink    i_pix,
    npcm_res_if.source  o_res,
    npcm_cfg_if.sink    i_cfg
);
    import npcm_pkg::*;

    t_cmd    w_cmd;
    t_status w_status;
    logic    w_in_ready;
    logic    w_out_valid;

    // Sequencer: owns the input ready and the result valid
    npcm_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_pix.valid),
        .i_in_op     (i_pix.operation),
        .o_in_ready  (w_in_ready),
        .o_out_valid (w_out_valid),
        .i_out_ready (o_res.ready),
        .i_status    (w_status),
        .o_cmd       (w_cmd)
    );

    // Datapath: tables, distance pipe, mask packer, result payload
    npcm_dp #(
        .PALETTE_ENTRIES (PALETTE_ENTRIES),
        .MAX_LINE_WIDTH  (MAX_LINE_WIDTH)
    ) u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (w_cmd),
        .o_status          (w_status),
        .i_pixel_word      (i_pix.pixel_word),
        .i_entry_index     (i_pix.entry_index),
        .i_entry_word      (i_pix.entry_word),
        .i_cfg_valid       (i_cfg.valid),
        .i_cfg_index       (i_cfg.index),
        .i_cfg_data        (i_cfg.data),
        .o_pen             (o_res.pen),
        .o_opaque          (o_res.opaque),
        .o_mask_byte       (o_res.mask_byte),
        .o_mask_byte_ready (o_res.mask_byte_ready)
    );

    assign i_pix.ready = w_in_ready;
    assign o_res.valid = w_out_valid;
    // register writes are never stalled and land when accepted
    assign i_cfg.ready = 1'b1;
endmodule

@@ verif/tb_nearest_palette_color_mapper_unit.sv @@
// -----------------------------------------------------------------------------
// tb_nearest_palette_color_mapper_unit
// Self-checking bench for the nearest palette color mapper. After the palette
// and pen tables are loaded, a short table of directed items runs first.
// Random phases follow, each with its own register setting and idle pattern.
// A shadow copy of the tables, the registers, the column counter and the mask
// accumulator predicts pen, opaque bit and mask byte for every pixel item.
// -----------------------------------------------------------------------------
module tb_nearest_palette_color_mapper_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import npcm_pkg::*;

    // Codes the package leaves unnamed
    localparam logic [OP_W-1:0]  OP_UNUSED   = 2'd3;
    localparam logic [FMT_W-1:0] FMT_UNKNOWN = 2'd3;

    localparam int CLK_HALF       = 5;
    localparam int RESET_CYCLES   = 6;
    localparam int NUM_ENTRIES    = PALETTE_ENTRIES_DEF;
    localparam int WIDTH_CAP      = MAX_LINE_WIDTH_DEF;
    // Hold-off after draining, longer than a pixel's full palette scan.
    localparam int HOLD_CYCLES    = NUM_ENTRIES + 40;
    // No handshake for this long means the block hung.
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int RAND_ITEMS     = 600;

    typedef struct packed {
        logic [PEN_W-1:0]  pen;
        logic              opaque;
        logic [MASK_W-1:0] mask_byte;
        logic              mask_byte_ready;
    } t_mapped_px;

    typedef enum logic {ROW_ITEM, ROW_REG} t_row_kind;

    typedef struct {
        t_row_kind             kind;
        logic [OP_W-1:0]       op;
        logic [WORD_W-1:0]     pixel_word;
        logic [IDX_W-1:0]      entry_index;
        logic [WORD_W-1:0]     entry_word;
        bit                    known;      // pen typed in below, mask inactive
        logic [PEN_W-1:0]      known_pen;
        logic [CFG_IDX_W-1:0]  reg_idx;
        logic [CFG_DATA_W-1:0] reg_val;
    } t_stim_row;

    logic i_clk;
    logic i_rst_n;

    npcm_pix_if pix_if ();
    npcm_res_if res_if ();
    npcm_cfg_if cfg_if ();

    nearest_palette_color_mapper_unit uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pix   (pix_if),
        .o_res   (res_if),
        .i_cfg   (cfg_if)
    );

    always #(CLK_HALF) i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Shadow state of the block
    // ------------------------------------------------------------------
    logic [WORD_W-1:0] palette_shadow [NUM_ENTRIES];
    logic [PEN_W-1:0]  pen_shadow     [256];
    int unsigned       column_pos;
    logic [MASK_W-1:0] mask_bits;
    logic [FMT_W-1:0]  fmt_reg;
    logic [LW_W-1:0]   width_reg;
    logic              mask_en_reg;
    logic              remap_reg;

    // Pixel results still to come, oldest first
    t_mapped_px mapped_q [$];

    int send_gap_pct;
    int recv_stall_pct;
    int mismatches;
    int pixels_sent;
    int table_writes;
    int reg_writes;
    int results_seen;
    int mask_bytes_seen;
    int phases_run;
    int quiet_cycles;

    // ------------------------------------------------------------------
    // Predictor: applies one accepted item to the shadow state and, for a
    // pixel, works out the result item it should produce.
    // ------------------------------------------------------------------
    task automatic predict_mapping(input logic [OP_W-1:0] op,
                                   input logic [WORD_W-1:0] pw,
                                   input logic [IDX_W-1:0] ei,
                                   input logic [WORD_W-1:0] ew,
                                   output bit produces,
                                   output t_mapped_px res);
        logic [WORD_W-1:0] argb;
        logic [WORD_W-1:0] ent;
        logic [7:0]        best;
        int unsigned       best_err;
        int unsigned       err;
        int                dr, dg, db;
        int unsigned       eff_width;
        int unsigned       bitpos;
        bit                active, opaque, row_end, exact;
        produces = 1'b0;
        res      = '0;
        case (op)
            OP_PAL_WR: palette_shadow[ei] = ew;
            OP_PEN_WR: pen_shadow[ei] = ew[PEN_W-1:0];
            OP_PIXEL: begin
                case (fmt_reg)
                    FMT_CLUT8:  argb = palette_shadow[pw[7:0]];
                    FMT_RGB24:  argb = {ALPHA_FULL, pw[23:0]};
                    FMT_ARGB32: argb = pw;
                    default:    argb = '0;   // unknown format reads as black
                endcase

                // Full scan, first strictly smaller error wins, so ties keep
                // the lowest index; a zero error just stops early.
                best     = '0;
                best_err = 32'hFFFF_FFFF;
                exact    = 1'b0;
                for (int i = 0; i < NUM_ENTRIES && !exact; i++) begin
                    ent = palette_shadow[i];
                    dr  = int'(ent[23:16]) - int'(argb[23:16]);
                    dg  = int'(ent[15:8])  - int'(argb[15:8]);
                    db  = int'(ent[7:0])   - int'(argb[7:0]);
                    err = dr * dr + dg * dg + db * db;
                    if (err < best_err) begin
                        best_err = err;
                        best     = i[7:0];
                        exact    = (err == 0);
                    end
                end

                active = (fmt_reg == FMT_ARGB32) && mask_en_reg;
                opaque = active && (argb[31:24] >= OPAQUE_MIN);

                // Zero width acts as one, oversize widths are clamped
                if (width_reg == 0)
                    eff_width = 1;
                else if (width_reg > WIDTH_CAP)
                    eff_width = WIDTH_CAP;
                else
                    eff_width = 32'(width_reg);

                bitpos = column_pos & 7;
                if (opaque)
                    mask_bits = mask_bits | (MASK_MSB >> bitpos);
                // A column past a shrunk row counts as the row end
                row_end = (column_pos + 1 >= eff_width);
                if (bitpos == 7 || row_end) begin
                    if (active) begin
                        res.mask_byte_ready = 1'b1;
                        res.mask_byte       = mask_bits;
                    end
                    mask_bits = '0;
                end
                column_pos = row_end ? 0 : column_pos + 1;

                res.pen    = remap_reg ? pen_shadow[best] : best;
                res.opaque = opaque;
                produces   = 1'b1;
            end
            default: ;   // unused operation: nothing happens
        endcase
    endtask

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("ERROR at %0t ns: %s: got 0x%0h, want 0x%0h", $time, what, got, want);
        mismatches++;
    endtask

    // ------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------

    // One input item: optional random gap, then hold valid until accepted.
    // Valid stays high into the next call unless that call idles first.
    task automatic send_item(input logic [OP_W-1:0] op,
                             input logic [WORD_W-1:0] pw,
                             input logic [IDX_W-1:0] ei,
                             input logic [WORD_W-1:0] ew,
                             input bit known,
                             input logic [PEN_W-1:0] known_pen);
        bit         produces;
        t_mapped_px predicted;
        while ($urandom_range(99) < send_gap_pct) begin
            pix_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        pix_if.valid       <= 1'b1;
        pix_if.operation   <= op;
        pix_if.pixel_word  <= pw;
        pix_if.entry_index <= ei;
        pix_if.entry_word  <= ew;
        @(posedge i_clk);
        while (!pix_if.ready) @(posedge i_clk);

        predict_mapping(op, pw, ei, ew, produces, predicted);
        if (produces) begin
            if (known) begin
                predicted        = '0;
                predicted.pen    = known_pen;
            end
            mapped_q.push_back(predicted);
            pixels_sent++;
        end else if (op != OP_UNUSED) begin
            table_writes++;
        end
    endtask

    // Register write; caller lowers valid after the last one of a burst.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= val;
        @(posedge i_clk);
        while (!cfg_if.ready) @(posedge i_clk);
        case (idx)
            REG_IMAGE_FORMAT: fmt_reg     = val[FMT_W-1:0];
            REG_LINE_WIDTH:   width_reg   = val[LW_W-1:0];
            REG_MASK_ENABLE:  mask_en_reg = val[0];
            REG_PEN_REMAP:    remap_reg   = val[0];
            default: ;
        endcase
        reg_writes++;
    endtask

    // Stop sending, wait for every result, then give a trailing table write
    // time to retire before the registers are touched.
    task automatic drain_and_hold();
        pix_if.valid <= 1'b0;
        while (mapped_q.size() != 0) @(posedge i_clk);
        repeat (HOLD_CYCLES) @(posedge i_clk);
    endtask

    function automatic t_stim_row item_row(input logic [OP_W-1:0] op,
                                           input logic [WORD_W-1:0] pw,
                                           input logic [IDX_W-1:0] ei,
                                           input logic [WORD_W-1:0] ew,
                                           input bit known,
                                           input logic [PEN_W-1:0] known_pen);
        t_stim_row row;
        row.kind        = ROW_ITEM;
        row.op          = op;
        row.pixel_word  = pw;
        row.entry_index = ei;
        row.entry_word  = ew;
        row.known       = known;
        row.known_pen   = known_pen;
        row.reg_idx     = '0;
        row.reg_val     = '0;
        return row;
    endfunction

    function automatic t_stim_row reg_row(input logic [CFG_IDX_W-1:0] idx,
                                          input logic [CFG_DATA_W-1:0] val);
        t_stim_row row;
        row             = item_row(OP_UNUSED, '0, '0, '0, 1'b0, '0);
        row.kind        = ROW_REG;
        row.reg_idx     = idx;
        row.reg_val     = val;
        return row;
    endfunction

    function automatic logic [7:0] coarse_level();
        case ($urandom_range(4))
            0:       return 8'h00;
            1:       return 8'h40;
            2:       return 8'h80;
            3:       return 8'hC0;
            default: return 8'hFF;
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Result checker and receiver stalls
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : res_monitor
        t_mapped_px want;
        if (i_rst_n && res_if.valid && res_if.ready) begin
            results_seen++;
            if (res_if.mask_byte_ready)
                mask_bytes_seen++;
            if (mapped_q.size() == 0) begin
                report_mismatch("result item with none awaited", 32'(res_if.pen), 0);
            end else begin
                want = mapped_q.pop_front();
                if (res_if.pen !== want.pen)
                    report_mismatch("pen", 32'(res_if.pen), 32'(want.pen));
                if (res_if.opaque !== want.opaque)
                    report_mismatch("opaque", 32'(res_if.opaque), 32'(want.opaque));
                if (res_if.mask_byte !== want.mask_byte)
                    report_mismatch("mask_byte", 32'(res_if.mask_byte),
                                    32'(want.mask_byte));
                if (res_if.mask_byte_ready !== want.mask_byte_ready)
                    report_mismatch("mask_byte_ready", 32'(res_if.mask_byte_ready),
                                    32'(want.mask_byte_ready));
            end
        end
        res_if.ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Watchdog: cycles without any handshake on any channel
    always @(posedge i_clk) begin
        if (!i_rst_n || (pix_if.valid && pix_if.ready) || (res_if.valid && res_if.ready)
            || (cfg_if.valid && cfg_if.ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("Watchdog expired after %0d quiet cycles at %0t ns",
                         quiet_cycles, $time);
                $display("Mismatches found");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    initial begin : stimulus
        t_stim_row         plan [$];
        t_stim_row         row;
        bit                in_reg_burst;
        int                rnd_items;
        int                n_items;
        int                pick;
        logic [OP_W-1:0]   op;
        logic [WORD_W-1:0] pw;
        logic [WORD_W-1:0] ew;
        logic [7:0]        alpha;
        logic [FMT_W-1:0]  fmt_sel;
        logic [LW_W-1:0]   width_sel;
        logic              mask_sel;
        logic              remap_sel;

        // Known levels on every input from time zero
        i_clk              = 1'b0;
        i_rst_n            = 1'b0;
        pix_if.valid       = 1'b0;
        pix_if.operation   = OP_PIXEL;
        pix_if.pixel_word  = '0;
        pix_if.entry_index = '0;
        pix_if.entry_word  = '0;
        cfg_if.valid       = 1'b0;
        cfg_if.index       = REG_IMAGE_FORMAT;
        cfg_if.data        = '0;
        res_if.ready       = 1'b0;

        send_gap_pct    = 0;
        recv_stall_pct  = 0;
        mismatches      = 0;
        pixels_sent     = 0;
        table_writes    = 0;
        reg_writes      = 0;
        results_seen    = 0;
        mask_bytes_seen = 0;
        phases_run      = 0;
        quiet_cycles    = 0;

        // Shadow reset values
        column_pos  = 0;
        mask_bits   = '0;
        fmt_reg     = FMT_CLUT8;
        width_reg   = LW_W'(1);
        mask_en_reg = 1'b0;
        remap_reg   = 1'b0;

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Every table entry is written before the first pixel. Gray ramp
        // with alpha = index makes the directed results easy to read off;
        // the pen table holds the inverted index.
        for (int i = 0; i < NUM_ENTRIES; i++)
            send_item(OP_PAL_WR, $urandom(), i[7:0], {4{i[7:0]}}, 1'b0, '0);
        for (int i = 0; i < 256; i++)
            send_item(OP_PEN_WR, $urandom(), i[7:0], {16'($urandom_range(16'hFFFF, 0)),
                      8'h00, ~i[7:0]}, 1'b0, '0);

        // ---- directed table (reset setting: CLUT8, width 1, no mask/remap)
        plan.push_back(item_row(OP_PIXEL,  32'h0000_0000, 8'h00, 32'h0000_0000, 1'b1, 8'd0));
        plan.push_back(item_row(OP_PIXEL,  32'hFFFF_FFFF, 8'hFF, 32'hFFFF_FFFF, 1'b1, 8'd255));
        plan.push_back(item_row(OP_UNUSED, 32'hFFFF_FFFF, 8'hFF, 32'hFFFF_FFFF, 1'b0, '0));
        // white at 254 duplicates 255: equal distance resolves to the lower index
        plan.push_back(item_row(OP_PAL_WR, 32'h0000_0000, 8'd254, 32'hFFFF_FFFF, 1'b0, '0));
        plan.push_back(item_row(OP_PIXEL,  32'h0000_00FE, 8'h00, 32'h0000_0000, 1'b1, 8'd254));
        plan.push_back(item_row(OP_PAL_WR, 32'hFFFF_FFFF, 8'd254, 32'hFEFE_FEFE, 1'b0, '0));
        plan.push_back(item_row(OP_PIXEL,  32'h1234_5680, 8'h00, 32'h0000_0000, 1'b1, 8'd128));
        // RGB24: alpha bits are ignored
        plan.push_back(reg_row(REG_IMAGE_FORMAT, CFG_DATA_W'(FMT_RGB24)));
        plan.push_back(item_row(OP_PIXEL,  32'hFF00_0000, 8'h00, 32'h0000_0000, 1'b1, 8'd0));
        plan.push_back(item_row(OP_PIXEL,  32'h00FF_FFFF, 8'h00, 32'h0000_0000, 1'b1, 8'd255));
        plan.push_back(item_row(OP_PIXEL,  32'h0001_0000, 8'h00, 32'h0000_0000, 1'b0, '0));
        // unknown format decodes as black
        plan.push_back(reg_row(REG_IMAGE_FORMAT, CFG_DATA_W'(FMT_UNKNOWN)));
        plan.push_back(item_row(OP_PIXEL,  32'hFFFF_FFFF, 8'h00, 32'h0000_0000, 1'b1, 8'd0));
        // ARGB32 with mask and remap, three pixels per row
        plan.push_back(reg_row(REG_IMAGE_FORMAT, CFG_DATA_W'(FMT_ARGB32)));
        plan.push_back(reg_row(REG_LINE_WIDTH, 13'd3));
        plan.push_back(reg_row(REG_MASK_ENABLE, 13'd1));
        plan.push_back(reg_row(REG_PEN_REMAP, 13'd1));
        plan.push_back(item_row(OP_PIXEL,  32'h80FF_FFFF, 8'h00, 32'h0000_0000, 1'b0, '0));
        plan.push_back(item_row(OP_PIXEL,  32'h7F00_0000, 8'h00, 32'h0000_0000, 1'b0, '0));
        plan.push_back(item_row(OP_PIXEL,  32'hFF80_8080, 8'h00, 32'h0000_0000, 1'b0, '0));
        plan.push_back(item_row(OP_PEN_WR, 32'h0000_0000, 8'hFF, 32'h1234_5678, 1'b0, '0));
        plan.push_back(item_row(OP_PIXEL,  32'h00FF_FFFF, 8'h00, 32'h0000_0000, 1'b0, '0));
        // width 0 acts as 1, and the column now lies past the row end
        plan.push_back(reg_row(REG_LINE_WIDTH, 13'd0));
        plan.push_back(item_row(OP_PIXEL,  32'hFFFF_FFFF, 8'h00, 32'h0000_0000, 1'b0, '0));
        // oversize width clamps; eight pixels close one full mask group
        plan.push_back(reg_row(REG_LINE_WIDTH, 13'h1FFF));
        plan.push_back(reg_row(REG_PEN_REMAP, 13'd0));
        for (int i = 0; i < 8; i++)
            plan.push_back(item_row(OP_PIXEL, i[0] ? 32'h7F12_3456 : 32'h80AB_CDEF,
                                    8'h00, 32'h0000_0000, 1'b0, '0));

        in_reg_burst = 1'b0;
        foreach (plan[r]) begin
            row = plan[r];
            if (row.kind == ROW_REG) begin
                if (!in_reg_burst)
                    drain_and_hold();
                in_reg_burst = 1'b1;
                write_reg(row.reg_idx, row.reg_val);
            end else begin
                if (in_reg_burst)
                    cfg_if.valid <= 1'b0;
                in_reg_burst = 1'b0;
                send_item(row.op, row.pixel_word, row.entry_index, row.entry_word,
                          row.known, row.known_pen);
            end
        end

        // ---- random phases
        rnd_items = 0;
        while (rnd_items < RAND_ITEMS) begin
            drain_and_hold();

            // First four phases pin the register extremes
            case (phases_run)
                0: begin
                    fmt_sel = FMT_ARGB32; width_sel = 13'h1FFF; mask_sel = 1'b1;
                    remap_sel = 1'b0;
                end
                1: begin
                    fmt_sel = FMT_UNKNOWN; width_sel = 13'd0; mask_sel = 1'b1;
                    remap_sel = 1'b1;
                end
                2: begin
                    fmt_sel = FMT_CLUT8; width_sel = 13'd4096; mask_sel = 1'b0;
                    remap_sel = 1'b1;
                end
                3: begin
                    fmt_sel = FMT_RGB24; width_sel = 13'd1; mask_sel = 1'b1;
                    remap_sel = 1'b0;
                end
                default: begin
                    fmt_sel   = ($urandom_range(1) == 0) ? FMT_ARGB32
                                                         : FMT_W'($urandom_range(3));
                    pick      = $urandom_range(99);
                    if (pick < 60)
                        width_sel = LW_W'($urandom_range(20, 1));
                    else if (pick < 70)
                        width_sel = 13'd0;
                    else if (pick < 80)
                        width_sel = LW_W'($urandom_range(8191, 4096));
                    else
                        width_sel = LW_W'($urandom_range(4096, 1));
                    mask_sel  = ($urandom_range(3) != 0);
                    remap_sel = 1'($urandom_range(1));
                end
            endcase

            // Idle pattern cycles: none, sender, receiver, both lightly
            case (phases_run % 4)
                0: begin send_gap_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_gap_pct = 45; recv_stall_pct = 0;  end
                2: begin send_gap_pct = 0;  recv_stall_pct = 45; end
                default: begin send_gap_pct = 7; recv_stall_pct = 7; end
            endcase

            write_reg(REG_IMAGE_FORMAT, CFG_DATA_W'(fmt_sel));
            write_reg(REG_LINE_WIDTH, width_sel);
            write_reg(REG_MASK_ENABLE, CFG_DATA_W'(mask_sel));
            write_reg(REG_PEN_REMAP, CFG_DATA_W'(remap_sel));
            cfg_if.valid <= 1'b0;

            n_items = $urandom_range(50, 30);
            for (int k = 0; k < n_items; k++) begin
                pick = $urandom_range(99);
                if (pick < 78)
                    op = OP_PIXEL;
                else if (pick < 90)
                    op = OP_PAL_WR;
                else if (pick < 97)
                    op = OP_PEN_WR;
                else
                    op = OP_UNUSED;

                // alpha often straddles the opaque threshold
                case ($urandom_range(3))
                    0:       alpha = 8'h7F;
                    1:       alpha = 8'h80;
                    default: alpha = 8'($urandom_range(255));
                endcase

                // pixel content: random, exact palette copy, or coarse levels
                // that tend to tie against coarse palette entries
                case ($urandom_range(3))
                    0: pw = $urandom();
                    1: pw = {alpha, palette_shadow[$urandom_range(NUM_ENTRIES - 1)][23:0]};
                    2: pw = {alpha, coarse_level(), coarse_level(), coarse_level()};
                    default: pw = {alpha, 24'($urandom())};
                endcase

                if ($urandom_range(99) < 60)
                    ew = {8'($urandom()), coarse_level(), coarse_level(), coarse_level()};
                else
                    ew = $urandom();

                send_item(op, pw, 8'($urandom_range(255)), ew, 1'b0, '0);
                if (op != OP_UNUSED)
                    rnd_items++;
            end
            phases_run++;
        end

        // ---- wind down
        drain_and_hold();
        if (mapped_q.size() != 0)
            report_mismatch("results never delivered", mapped_q.size(), 0);

        $display("Covered %0d pixels and %0d table writes, %0d register writes, %0d phases.",
                 pixels_sent, table_writes, reg_writes, phases_run);
        $display("Checked %0d result items, %0d of them with a mask byte.",
                 results_seen, mask_bytes_seen);
        if (mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
